// ----- src/lzd_pkg.sv -----
`timescale 1ns / 1ps

package lzd_pkg;

    localparam int WINDOW_BYTES_DEF   = 4096;
    localparam int SHORTEST_MATCH_DEF = 3;
    localparam int TOKENS_PER_FLAG    = 8;
    localparam int LEN_FIELD_MAX      = 15;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_SECOND = 2'd2,
        PH_BAD    = 2'd3
    } t_phase;

    typedef struct packed {
        logic accept;
        logic rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic start_copy;
        logic copy_last;
    } t_status;

endpackage

// ----- src/lzd_ram.sv -----
`timescale 1ns / 1ps

module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/lzd_ctrl.sv -----
`timescale 1ns / 1ps

module lzd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  lzd_pkg::t_status i_status,
    output lzd_pkg::t_cmd    o_cmd
);

    import lzd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.out_free && i_status.start_copy) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.copy_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = !i_status.out_free;
                o_cmd.accept = i_in_valid && i_status.out_free;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/lzd_datapath.sv -----
`timescale 1ns / 1ps

module lzd_datapath #(
    parameter int WINDOW_BYTES   = lzd_pkg::WINDOW_BYTES_DEF,
    parameter int SHORTEST_MATCH = lzd_pkg::SHORTEST_MATCH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lzd_pkg::t_cmd    i_cmd,
    output lzd_pkg::t_status o_status,
    input  logic [7:0]       i_in_byte,
    input  logic             i_stream_last,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last
);

    import lzd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int FW = AW + 1;
    localparam int CW = $clog2(LEN_FIELD_MAX + SHORTEST_MATCH + 1);

    logic [AW-1:0] r_wp,      n_wp;
    logic [FW-1:0] r_fill,    n_fill;
    t_phase        r_phase,   n_phase;
    logic [7:0]    r_flags,   n_flags;
    logic [3:0]    r_tokens,  n_tokens;
    logic [7:0]    r_first,   n_first;
    logic [FW-1:0] r_dist,    n_dist;
    logic [CW-1:0] r_count,   n_count;
    logic          r_last,    n_last;
    logic          r_zero,    n_zero;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte,  n_out_byte;
    logic          r_out_last,  n_out_last;

    logic          ram_wr_en;
    logic [7:0]    ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    logic [7:0]    copy_byte;
    logic [3:0]    tokens_dec;
    logic          out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign ram_rd_addr = r_wp - r_dist[AW-1:0];
    assign copy_byte   = r_zero ? 8'd0 : ram_rd_data;
    assign tokens_dec  = (r_tokens != 4'd0) ? r_tokens - 4'd1 : 4'd0;

    assign o_status.out_free   = out_free;
    assign o_status.start_copy = (r_phase == PH_SECOND);
    assign o_status.copy_last  = (r_count == CW'(1));

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_phase     = r_phase;
        n_flags     = r_flags;
        n_tokens    = r_tokens;
        n_first     = r_first;
        n_dist      = r_dist;
        n_count     = r_count;
        n_last      = r_last;
        n_zero      = r_zero;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        ram_wr_en   = 1'b0;
        ram_wr_data = i_in_byte;

        if (i_cmd.accept) begin
            unique case (r_phase)
                PH_TOKEN: begin
                    if (!r_flags[0]) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = i_in_byte;
                        n_out_last  = 1'b1;
                        ram_wr_en   = 1'b1;
                        n_wp        = r_wp + AW'(1);
                        if (r_fill != FW'(WINDOW_BYTES)) begin
                            n_fill = r_fill + FW'(1);
                        end
                        n_flags  = {1'b0, r_flags[7:1]};
                        n_tokens = tokens_dec;
                        n_phase  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                    end else begin
                        n_first = i_in_byte;
                        n_phase = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    n_dist   = FW'({r_first, i_in_byte[7:4]}) + FW'(1);
                    n_count  = CW'(i_in_byte[3:0]) + CW'(SHORTEST_MATCH);
                    n_last   = i_stream_last;
                    n_flags  = {1'b0, r_flags[7:1]};
                    n_tokens = tokens_dec;
                    n_phase  = (tokens_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
                end
                PH_FLAG, PH_BAD: begin
                    n_flags  = i_in_byte;
                    n_tokens = 4'(TOKENS_PER_FLAG);
                    n_phase  = PH_TOKEN;
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
            if (i_stream_last) begin
                n_phase  = PH_FLAG;
                n_flags  = 8'd0;
                n_tokens = 4'd0;
                n_first  = 8'd0;
                // a reference resets position and fill once its copy ends
                if (r_phase != PH_SECOND) begin
                    n_wp   = '0;
                    n_fill = '0;
                end
            end
        end

        if (i_cmd.rd) begin
            n_zero = (r_dist > r_fill);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = copy_byte;
            n_out_last  = (r_count == CW'(1));
            ram_wr_en   = 1'b1;
            ram_wr_data = copy_byte;
            n_wp        = r_wp + AW'(1);
            if (r_fill != FW'(WINDOW_BYTES)) begin
                n_fill = r_fill + FW'(1);
            end
            n_count = r_count - CW'(1);
            if ((r_count == CW'(1)) && r_last) begin
                n_wp   = '0;
                n_fill = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_phase     <= PH_FLAG;
            r_flags     <= '0;
            r_tokens    <= '0;
            r_first     <= '0;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_flags     <= n_flags;
            r_tokens    <= n_tokens;
            r_first     <= n_first;
            r_count     <= n_count;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist     <= n_dist;
        r_zero     <= n_zero;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

endmodule

// ----- src/lzss_decompressor_top.sv -----
// LZSS decompressor, 4096-byte history window.
// Input channel: one compressed byte per request on i_in_byte, with
// i_stream_last on the final byte of a stream. Output channel: one
// decompressed byte per request on o_out_byte; o_run_last marks the last
// byte produced by a given input byte.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low.
// Flag bytes and first reference bytes produce nothing. A literal
// appears on the output register in the cycle after it is accepted.
// A reference copies 3 to 18 bytes; after it is accepted, each copied
// byte takes a history RAM read, then an emit and write back. The
// input is taken only between items. When the receiver stalls, the
// output register holds its byte and the block waits; no byte is lost.
// After reset, and after any stream_last byte, the next byte is a flag
// byte and the history reads as empty (zero). No clearing pass is
// needed after reset.
`timescale 1ns / 1ps

module lzss_decompressor_top #(
    parameter int WINDOW_BYTES   = lzd_pkg::WINDOW_BYTES_DEF,
    parameter int SHORTEST_MATCH = lzd_pkg::SHORTEST_MATCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    import lzd_pkg::*;

    t_cmd    cmd;
    t_status status;

    lzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lzd_datapath #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .SHORTEST_MATCH (SHORTEST_MATCH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_byte     (i_in_byte),
        .i_stream_last (i_stream_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

endmodule
